// ===== design/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types for the signed word sorter: beat payloads and the control
// groups passed between the sequencer and the store.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     end_of_set;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     last_result;
    logic                     overflowed;
  } out_beat_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_PUT  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ===== design/sws_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sws_ctrl
// Insertion and drain sequencer: one shared signed comparator walks the
// store downward, shifting one entry per cycle, then reads the set out.
// ----------------------------------------------------------------------------
module sws_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire sws_pkg::in_beat_t           item,
  input  wire logic [sws_pkg::WORD_W-1:0]  rdata,
  output sws_pkg::mem_ctl_t                mem_ctl,
  output logic [AW-1:0]                    waddr,
  output logic [AW-1:0]                    raddr,
  output logic [sws_pkg::WORD_W-1:0]       wdata,
  output sws_pkg::emit_t                   emit
);

  localparam int CW = $clog2(CAPACITY + 1);

  sws_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [AW-1:0] idx, idx_next;
  logic          ovf, ovf_next;
  logic [sws_pkg::WORD_W-1:0] v, v_next;
  logic          closing, closing_next;
  sws_pkg::emit_t emit_next;
  logic          greater;
  logic          at_last;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] pos_m2;

  assign busy     = (state != sws_pkg::S_IDLE);
  assign greater  = $signed(rdata) > $signed(v);
  assign count_m1 = count - CW'(1);
  assign pos_m2   = pos - CW'(2);
  assign at_last  = (CW'(idx) == count_m1);

  always_comb begin
    state_next   = state;
    count_next   = count;
    pos_next     = pos;
    idx_next     = idx;
    ovf_next     = ovf;
    v_next       = v;
    closing_next = closing;
    mem_ctl      = '0;
    waddr        = '0;
    raddr        = '0;
    wdata        = v;
    emit_next    = '0;
    case (state)
      sws_pkg::S_IDLE: begin
        idx_next = '0;
        if (start) begin
          v_next       = item.value;
          closing_next = item.end_of_set;
          if (count < CW'(CAPACITY)) begin
            if (count == '0) begin
              mem_ctl.we = 1'b1;
              wdata      = item.value;
              count_next = CW'(1);
              if (item.end_of_set) begin
                state_next = sws_pkg::S_EMIT;
              end
            end else begin
              mem_ctl.re = 1'b1;
              raddr      = count_m1[AW-1:0];
              pos_next   = count;
              state_next = sws_pkg::S_INS;
            end
          end else begin
            ovf_next = 1'b1;
            if (item.end_of_set) begin
              state_next = sws_pkg::S_EMIT;
            end
          end
        end
      end
      sws_pkg::S_INS: begin
        mem_ctl.we = 1'b1;
        waddr      = pos[AW-1:0];
        if (greater) begin
          wdata = rdata;
          if (pos == CW'(1)) begin
            pos_next   = '0;
            state_next = sws_pkg::S_PUT;
          end else begin
            mem_ctl.re = 1'b1;
            raddr      = pos_m2[AW-1:0];
            pos_next   = pos - CW'(1);
          end
        end else begin
          wdata      = v;
          count_next = count + CW'(1);
          state_next = closing ? sws_pkg::S_EMIT : sws_pkg::S_IDLE;
        end
      end
      sws_pkg::S_PUT: begin
        mem_ctl.we = 1'b1;
        waddr      = '0;
        wdata      = v;
        count_next = count + CW'(1);
        state_next = closing ? sws_pkg::S_EMIT : sws_pkg::S_IDLE;
      end
      sws_pkg::S_EMIT: begin
        mem_ctl.re     = 1'b1;
        raddr          = idx;
        emit_next.valid = 1'b1;
        emit_next.last  = at_last;
        emit_next.ovf   = ovf;
        if (at_last) begin
          count_next = '0;
          ovf_next   = 1'b0;
          idx_next   = '0;
          state_next = sws_pkg::S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      default: begin
        state_next = sws_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sws_pkg::S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      idx   <= '0;
      emit  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      idx   <= idx_next;
      emit  <= emit_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    v       <= v_next;
    closing <= closing_next;
  end

endmodule
`default_nettype wire

// ===== design/signed_word_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_word_sorter
// Insertion sort of signed 32-bit words into an on-chip store; a beat with
// end_of_set drains the set in ascending order, one result beat per cycle.
// ----------------------------------------------------------------------------
// insert: written directly into an empty store, else the larger entries shift up
// (one store read and one write per cycle through a single comparator)
// closing beat: after the insert, one read per stored entry; results follow through
// the read and result registers, one per cycle; busy drops after the last read issues
// synchronous reset empties the set; store contents are not cleared
// results cannot be stalled by the receiver
module signed_word_sorter #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire sws_pkg::in_beat_t  item,
  output logic                    result_strobe,
  output sws_pkg::out_beat_t      result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  sws_pkg::mem_ctl_t              mem_ctl;
  logic [AW-1:0]                  waddr;
  logic [AW-1:0]                  raddr;
  logic [sws_pkg::WORD_W-1:0]     wdata;
  logic [sws_pkg::WORD_W-1:0]     rdata;
  sws_pkg::emit_t                 emit;
  logic [sws_pkg::WORD_W-1:0]     store [CAPACITY];

  sws_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .rdata   (rdata),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .raddr   (raddr),
    .wdata   (wdata),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      store[waddr] <= wdata;
    end
    if (mem_ctl.re) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.sorted_value <= rdata;
    result.last_result  <= emit.last;
    result.overflowed   <= emit.ovf;
  end

endmodule
`default_nettype wire
